// ===== rtl/serial_line_and_length_framer_assert.svh =====
// assertion macros used by the framer control module
`ifndef SERIAL_LINE_AND_LENGTH_FRAMER_ASSERT_SVH
`define SERIAL_LINE_AND_LENGTH_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SLF_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slf assertion failed");

// antecedent implies consequent in the following cycle
`define SLF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slf assertion failed");

// condition never holds
`define SLF_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("slf assertion failed");

`else

`define SLF_ASSERT_IMPLIES(label, ante, cons)
`define SLF_ASSERT_NEXT(label, ante, cons)
`define SLF_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== rtl/slf_pkg.sv =====
// shared constants, types and structs of the serial framer
package slf_pkg;

    // buffer geometry
    localparam int BUFFER_DEPTH = 32;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int RESULT_LIMIT = 32;
    localparam int IDX_W        = 5;
    localparam int BYTE_W       = 8;

    // protocol constants
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] NEWLINE     = 8'h0A;
    localparam logic [BYTE_W-1:0] HEADER_MARK = 8'h24;
    localparam int                HEADER_SIZE = 3;

    // configuration port
    localparam int   PADDR_W        = 3;
    localparam int   PDATA_W        = 32;
    localparam logic REG_FRAME_MODE = 1'b0;

    typedef enum logic {
        MODE_TEXT   = 1'b0,
        MODE_LENGTH = 1'b1
    } slf_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } slf_state_t;

    // configuration towards the controller
    typedef struct packed {
        logic      clear;
        slf_mode_t mode;
    } slf_cfg_t;

    // buffer access request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } slf_ram_req_t;

endpackage

// ===== rtl/serial_line_and_length_framer.sv =====
// Serial line and length framer: takes one received byte per input beat and
// stores it in a 32-entry byte buffer (single-port-write, registered-read
// memory). A byte that finishes a frame starts its emission: the frame is
// sent as result beats, each made of a buffer read state and an output beat
// state that waits out any output stall; no input beat is taken until the
// last result beat is delivered.
// frame_mode 0 gives newline-ended text frames, 1 gives '$'-headed frames
// with a length byte. Writing frame_mode abandons a partial frame.
module serial_line_and_length_framer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slf_pkg::PADDR_W-1:0]       paddr,
    input  logic [slf_pkg::PDATA_W-1:0]       pwdata,
    output logic [slf_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [slf_pkg::BYTE_W-1:0]        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [slf_pkg::BYTE_W-1:0]        frame_byte,
    output logic [slf_pkg::IDX_W-1:0]         byte_index,
    output logic                              overflowed,
    output logic                              last
);

    slf_pkg::slf_cfg_t     cfg;
    slf_pkg::slf_ram_req_t ram_req;

    // configuration registers
    slf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // framing control
    slf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_index (byte_index),
        .overflowed (overflowed),
        .last       (last),
        .ram_req    (ram_req)
    );

    // frame buffer
    slf_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (frame_byte)
    );

endmodule

// ===== rtl/slf_ram.sv =====
// frame byte buffer: one write port, one registered read port
module slf_ram (
    input  logic                             clk,
    input  slf_pkg::slf_ram_req_t            req,
    output logic [slf_pkg::BYTE_W-1:0]       rd_data
);

    logic [slf_pkg::BYTE_W-1:0] buffer_mem [slf_pkg::BUFFER_DEPTH];
    logic [slf_pkg::BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            buffer_mem[req.waddr] <= req.wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= buffer_mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/slf_cfg.sv =====
// apb register block holding the frame mode
module slf_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slf_pkg::PADDR_W-1:0]       paddr,
    input  logic [slf_pkg::PDATA_W-1:0]       pwdata,
    output logic [slf_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    output slf_pkg::slf_cfg_t                 cfg
);

    slf_pkg::slf_mode_t mode_reg;
    slf_pkg::slf_mode_t mode_next;
    logic               mode_wr;

    // register decode
    assign mode_wr = psel && penable && pwrite && (paddr[2] == slf_pkg::REG_FRAME_MODE);

    always_comb
    begin
        mode_next = mode_reg;
        if (mode_wr)
        begin
            mode_next = slf_pkg::slf_mode_t'(pwdata[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= slf_pkg::MODE_TEXT;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // read back and status
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == slf_pkg::REG_FRAME_MODE)
        begin
            prdata[0] = mode_reg;
        end
    end

    assign pready    = 1'b1;
    assign cfg.clear = mode_wr;
    assign cfg.mode  = mode_reg;

endmodule

// ===== rtl/slf_ctrl.sv =====
// frame assembly and emission sequencer around the byte buffer
`include "serial_line_and_length_framer_assert.svh"

module slf_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slf_pkg::slf_cfg_t                 cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [slf_pkg::BYTE_W-1:0]        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [slf_pkg::IDX_W-1:0]         byte_index,
    output logic                              overflowed,
    output logic                              last,
    output slf_pkg::slf_ram_req_t             ram_req
);

    localparam logic [slf_pkg::CNT_W-1:0]  FILL_FULL = slf_pkg::CNT_W'(slf_pkg::BUFFER_DEPTH);
    localparam logic [slf_pkg::CNT_W-1:0]  FILL_HDR  = slf_pkg::CNT_W'(slf_pkg::HEADER_SIZE);
    localparam logic [slf_pkg::BYTE_W-1:0] LEN_MAX   = 8'(slf_pkg::BUFFER_DEPTH);
    localparam logic [slf_pkg::BYTE_W-1:0] LEN_HDR   = 8'(slf_pkg::HEADER_SIZE);
    localparam logic [6:0]                 LIMIT_7   = 7'(slf_pkg::RESULT_LIMIT);

    slf_pkg::slf_state_t          state_reg;
    slf_pkg::slf_state_t          state_next;
    logic [slf_pkg::CNT_W-1:0]    fill_reg;
    logic [slf_pkg::CNT_W-1:0]    fill_next;
    logic [slf_pkg::BYTE_W-1:0]   len_reg;
    logic [slf_pkg::BYTE_W-1:0]   len_next;
    logic                         hdr_ok_reg;
    logic                         hdr_ok_next;
    logic [slf_pkg::IDX_W-1:0]    idx_reg;
    logic [slf_pkg::IDX_W-1:0]    idx_next;
    logic [slf_pkg::IDX_W-1:0]    last_idx_reg;
    logic [slf_pkg::IDX_W-1:0]    last_idx_next;
    logic                         over_reg;
    logic                         over_next;

    logic                         accept;
    logic                         is_last;
    logic                         emit;
    logic                         emit_over;
    logic [slf_pkg::CNT_W-1:0]    emit_cnt;
    logic [6:0]                   emit_cnt7;
    logic                         wr_en;
    logic [slf_pkg::CNT_W-1:0]    wr_pos;
    logic [slf_pkg::CNT_W-1:0]    base_fill;
    logic [slf_pkg::BYTE_W-1:0]   base_len;
    logic [slf_pkg::CNT_W-1:0]    fill_inc;

    assign accept    = in_valid && in_ready;
    assign is_last   = (idx_reg == last_idx_reg);
    assign emit_cnt7 = 7'(emit_cnt);

    // length mode restarts from an empty buffer if it ever ran full
    assign base_fill = (fill_reg >= FILL_FULL) ? '0 : fill_reg;
    assign base_len  = (fill_reg >= FILL_FULL) ? '0 : len_reg;
    assign fill_inc  = slf_pkg::CNT_W'(base_fill + 1'b1);

    // frame assembly decision for the accepted byte
    always_comb
    begin
        fill_next     = fill_reg;
        len_next      = len_reg;
        hdr_ok_next   = hdr_ok_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        over_next     = over_reg;
        emit          = 1'b0;
        emit_over     = 1'b0;
        emit_cnt      = '0;
        wr_en         = 1'b0;
        wr_pos        = fill_reg;

        if (cfg.clear)
        begin
            fill_next = '0;
            len_next  = '0;
        end
        else if (accept)
        begin
            unique case (cfg.mode)
                slf_pkg::MODE_TEXT:
                begin
                    if (rx_byte == slf_pkg::NEWLINE)
                    begin
                        // newline ends the frame, stored if there is room
                        fill_next = '0;
                        emit      = 1'b1;
                        if (fill_reg < FILL_FULL)
                        begin
                            wr_en    = 1'b1;
                            emit_cnt = slf_pkg::CNT_W'(fill_reg + 1'b1);
                        end
                        else
                        begin
                            emit_cnt = fill_reg;
                        end
                    end
                    else if (rx_byte != slf_pkg::ZERO_BYTE)
                    begin
                        if (fill_reg < FILL_FULL)
                        begin
                            wr_en     = 1'b1;
                            fill_next = slf_pkg::CNT_W'(fill_reg + 1'b1);
                        end
                        else
                        begin
                            // buffer full: drop byte, flush with overflow mark
                            fill_next = '0;
                            emit      = 1'b1;
                            emit_over = 1'b1;
                            emit_cnt  = fill_reg;
                        end
                    end
                end
                slf_pkg::MODE_LENGTH:
                begin
                    wr_en     = 1'b1;
                    wr_pos    = base_fill;
                    fill_next = fill_inc;
                    len_next  = base_len;
                    if (base_fill == '0)
                    begin
                        hdr_ok_next = (rx_byte == slf_pkg::HEADER_MARK);
                    end
                    else if (base_fill == slf_pkg::CNT_W'(1))
                    begin
                        hdr_ok_next = hdr_ok_reg && (rx_byte != slf_pkg::ZERO_BYTE);
                    end

                    if (fill_inc == FILL_HDR)
                    begin
                        // header check on the length byte
                        if (!hdr_ok_reg || (rx_byte == slf_pkg::ZERO_BYTE) ||
                            (rx_byte > LEN_MAX))
                        begin
                            fill_next = '0;
                            len_next  = '0;
                        end
                        else if (rx_byte <= LEN_HDR)
                        begin
                            // short length ends at the header
                            fill_next = '0;
                            len_next  = '0;
                            emit      = 1'b1;
                            emit_cnt  = FILL_HDR;
                        end
                        else
                        begin
                            len_next = rx_byte;
                        end
                    end
                    else if ((base_len != '0) && (8'(fill_inc) == base_len))
                    begin
                        fill_next = '0;
                        len_next  = '0;
                        emit      = 1'b1;
                        emit_cnt  = fill_inc;
                    end
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end

        // emission setup and walk
        if (emit)
        begin
            idx_next  = '0;
            over_next = emit_over;
            if (emit_cnt7 > LIMIT_7)
            begin
                last_idx_next = slf_pkg::IDX_W'(slf_pkg::RESULT_LIMIT - 1);
            end
            else
            begin
                last_idx_next = slf_pkg::IDX_W'(emit_cnt7 - 7'd1);
            end
        end
        else if ((state_reg == slf_pkg::ST_SHOW) && out_ready && !is_last)
        begin
            idx_next = slf_pkg::IDX_W'(idx_reg + 1'b1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slf_pkg::ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = slf_pkg::ST_READ;
                end
            end
            slf_pkg::ST_READ:
            begin
                state_next = slf_pkg::ST_SHOW;
            end
            slf_pkg::ST_SHOW:
            begin
                if (out_ready)
                begin
                    state_next = is_last ? slf_pkg::ST_IDLE : slf_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = slf_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs and buffer request
    always_comb
    begin
        in_ready      = (state_reg == slf_pkg::ST_IDLE);
        out_valid     = (state_reg == slf_pkg::ST_SHOW);
        ram_req.we    = wr_en;
        ram_req.waddr = slf_pkg::ADDR_W'(wr_pos);
        ram_req.wdata = rx_byte;
        ram_req.re    = (state_reg == slf_pkg::ST_READ);
        ram_req.raddr = slf_pkg::ADDR_W'(idx_reg);
    end

    assign byte_index = idx_reg;
    assign overflowed = over_reg;
    assign last       = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= slf_pkg::ST_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            hdr_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            hdr_ok_reg <= hdr_ok_next;
        end
    end

    // emission payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        over_reg     <= over_next;
    end

    // checks
    `SLF_ASSERT_NEVER(a_in_out_exclusive, in_ready && out_valid)
    `SLF_ASSERT_NEVER(a_fill_in_range, fill_reg > FILL_FULL)
    `SLF_ASSERT_IMPLIES(a_write_on_accept, ram_req.we, accept)
    `SLF_ASSERT_NEXT(a_last_returns_idle, out_valid && out_ready && last, in_ready)
    `SLF_ASSERT_NEXT(a_read_then_show, ram_req.re, out_valid)

endmodule
